// ----- hw/rtl/u16u8_pkg.sv -----
// Shared types, register indexes and the UTF-8 encoder for the UTF-16 to UTF-8 unit.
`default_nettype none

package u16u8_pkg;

	// Configuration register indexes.
	localparam int unsigned REG_INDEX_BITS = 2;
	localparam logic [REG_INDEX_BITS-1:0] REG_BUFFER_CAPACITY  = 2'd0;
	localparam logic [REG_INDEX_BITS-1:0] REG_POINTER_CAPACITY = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [15:0] BUFFER_CAPACITY_RESET  = 16'd4096;
	localparam logic [15:0] POINTER_CAPACITY_RESET = 16'd256;

	// Running state of the transcoder across code units.
	typedef struct packed {
		logic [9:0]  pending_high;
		logic        pending_valid;
		logic        at_var_start;
		logic [15:0] write_offset;
		logic [15:0] slot_count;
	} state_t;

	localparam state_t STATE_RESET = '{
		pending_high:  10'd0,
		pending_valid: 1'b0,
		at_var_start:  1'b1,
		write_offset:  16'd0,
		slot_count:    16'd0
	};

	// One result beat.
	typedef struct packed {
		logic [31:0] out_bytes;
		logic [2:0]  byte_count;
		logic [15:0] first_offset;
		logic        var_start;
		logic [15:0] var_offset;
		logic        block_end;
		logic [15:0] var_count;
	} result_t;

	// Encoded character: bytes packed first in bits 7 to 0, and their number.
	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  len;
	} utf8_t;

	// Encode one code point of up to 21 bits as one to four UTF-8 bytes.
	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.bytes = {24'd0, 1'b0, cp[6:0]};
			e.len   = 3'd1;
		end else if (cp < 21'h800) begin
			e.bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
			e.len   = 3'd2;
		end else if (cp < 21'h10000) begin
			e.bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
			e.len   = 3'd3;
		end else begin
			e.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
				5'b11110, cp[20:18]};
			e.len   = 3'd4;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/utf16_env_block_to_utf8_unit.sv -----
// Top level of the UTF-16 environment block to UTF-8 transcoder.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   code_unit
//   output    out        out_valid/out_stall out_bytes, byte_count, first_offset,
//                                            var_start, var_offset, block_end, var_count
//   config    in         wr_en               wr_index, wr_data
//
// One code unit per cycle is taken while the output is not stalled. Each yields one
// result beat via the input register, then the result register (step logic between).
// Reset clears the transcoder state and loads the capacity defaults.
// A stall on the output holds the result register and backs up into the input register.
`default_nettype none

module utf16_env_block_to_utf8_unit #(
	parameter int unsigned OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration writes.
	input  logic        wr_en,
	input  logic [u16u8_pkg::REG_INDEX_BITS-1:0] wr_index,
	input  logic [15:0] wr_data,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_bytes,
	output logic [2:0]  byte_count,
	output logic [15:0] first_offset,
	output logic        var_start,
	output logic [15:0] var_offset,
	output logic        block_end,
	output logic [15:0] var_count
);
	import u16u8_pkg::*;

	// Largest capacity that offsets of OFFSET_BITS bits can address.
	localparam logic [15:0] CAP_LIMIT = (OFFSET_BITS >= 16) ? 16'hFFFF
		: 16'((33'd1 << OFFSET_BITS) - 33'd1);

	logic [15:0] buf_cap_q;
	logic [15:0] ptr_cap_q;
	logic [15:0] eff_cap;
	logic        valid_s1;
	logic [15:0] code_unit_s1;
	logic        out_valid_q;
	result_t     res_q;
	state_t      st_q;
	state_t      st_next;
	result_t     res;
	logic        advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cap_q <= BUFFER_CAPACITY_RESET;
			ptr_cap_q <= POINTER_CAPACITY_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_BUFFER_CAPACITY) begin
				buf_cap_q <= wr_data;
			end
			if (wr_index == REG_POINTER_CAPACITY) begin
				ptr_cap_q <= wr_data;
			end
		end
	end

	assign eff_cap = (buf_cap_q > CAP_LIMIT) ? CAP_LIMIT : buf_cap_q;

	// The input register moves on whenever the result register can take a beat.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			code_unit_s1 <= code_unit;
		end
	end

	u16u8_core u_core (
		.st        (st_q),
		.code_unit (code_unit_s1),
		.buf_cap   (eff_cap),
		.ptr_cap   (ptr_cap_q),
		.st_next   (st_next),
		.res       (res)
	);

	// State and result register update when a unit moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_bytes    = res_q.out_bytes;
	assign byte_count   = res_q.byte_count;
	assign first_offset = res_q.first_offset;
	assign var_start    = res_q.var_start;
	assign var_offset   = res_q.var_offset;
	assign block_end    = res_q.block_end;
	assign var_count    = res_q.var_count;

`ifndef NO_ASSERTIONS
	// A stall toward the input only occurs while a unit is held.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no unit held");

	// A block end re-arms the state.
	a_block_end_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && res.block_end) |=>
		(st_q.write_offset == 16'd0 && st_q.slot_count == 16'd0 && st_q.at_var_start))
		else $error("state not re-armed after block end");

	// A variable start always counts itself.
	a_start_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.var_start) |-> (res_q.var_count != 16'd0))
		else $error("variable start with zero count");

	// A block end beat carries at most the single NUL byte.
	a_block_end_nul: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.block_end) |->
		(res_q.out_bytes == 32'd0 && res_q.byte_count <= 3'd1))
		else $error("block end beat carries content bytes");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/u16u8_core.sv -----
// Combinational step of the transcoder: next state and result for one code unit.
`default_nettype none

module u16u8_core (
	input  u16u8_pkg::state_t  st,
	input  logic [15:0]        code_unit,
	input  logic [15:0]        buf_cap,
	input  logic [15:0]        ptr_cap,
	output u16u8_pkg::state_t  st_next,
	output u16u8_pkg::result_t res
);
	import u16u8_pkg::*;

	logic        is_nul;
	logic        is_high;
	logic        is_low;
	logic        has_char;
	logic [20:0] cp;
	utf8_t       enc;
	logic [16:0] cap_w;
	logic [16:0] need_w;
	logic [16:0] room;
	logic [2:0]  count;
	logic [31:0] byte_mask;
	logic        take_slot;

	// Classify the unit.
	assign is_nul  = (code_unit == 16'd0);
	assign is_high = (code_unit[15:10] == 6'b110110);
	assign is_low  = (code_unit[15:10] == 6'b110111);

	// Code point: a merged surrogate pair or the unit itself.
	assign cp       = is_low ? (21'h10000 + {1'b0, st.pending_high, code_unit[9:0]})
		: {5'd0, code_unit};
	assign has_char = is_low ? st.pending_valid : !is_high;
	assign enc      = utf8_encode(cp);

	// Content bytes fit while the offset stays two below capacity.
	assign cap_w  = {1'b0, buf_cap};
	assign need_w = {1'b0, st.write_offset} + 17'd2;
	assign room   = (cap_w > need_w) ? (cap_w - need_w) : 17'd0;

	always_comb begin
		if (!has_char) begin
			count = 3'd0;
		end else if (room < {14'd0, enc.len}) begin
			count = room[2:0];
		end else begin
			count = enc.len;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			byte_mask[8*i +: 8] = (3'(i) < count) ? 8'hFF : 8'h00;
		end
	end

	// A new variable takes a slot while one is left before the closing slot.
	assign take_slot = ({1'b0, st.slot_count} + 17'd1) < {1'b0, ptr_cap};

	// Next state and result.
	always_comb begin
		st_next = st;
		res     = '0;
		if (is_nul) begin
			st_next.pending_high  = 10'd0;
			st_next.pending_valid = 1'b0;
			res.var_count         = st.slot_count;
			if (st.at_var_start) begin
				// Final NUL of the block, then re-arm.
				res.block_end = 1'b1;
				if (st.write_offset < buf_cap) begin
					res.byte_count   = 3'd1;
					res.first_offset = st.write_offset;
				end
				st_next.write_offset = 16'd0;
				st_next.slot_count   = 16'd0;
			end else begin
				// Terminator of one variable.
				if (({1'b0, st.write_offset} + 17'd1) < cap_w) begin
					res.byte_count       = 3'd1;
					res.first_offset     = st.write_offset;
					st_next.write_offset = st.write_offset + 16'd1;
				end
				st_next.at_var_start = 1'b1;
			end
		end else begin
			if (st.at_var_start) begin
				st_next.at_var_start = 1'b0;
				if (take_slot) begin
					res.var_start      = 1'b1;
					res.var_offset     = st.write_offset;
					st_next.slot_count = st.slot_count + 16'd1;
				end
			end
			if (is_high) begin
				st_next.pending_high  = code_unit[9:0];
				st_next.pending_valid = 1'b1;
			end else begin
				st_next.pending_high  = 10'd0;
				st_next.pending_valid = 1'b0;
			end
			res.out_bytes        = enc.bytes & byte_mask;
			res.byte_count       = count;
			res.first_offset     = (count != 3'd0) ? st.write_offset : 16'd0;
			st_next.write_offset = st.write_offset + {13'd0, count};
			res.var_count        = st_next.slot_count;
		end
	end

endmodule

`default_nettype wire
